### src/brhp_pkg.sv
// ----------------------------------------------------------------------------
// brhp_pkg
// Shared types, character codes and helpers for the byte range header parser.
// ----------------------------------------------------------------------------
package brhp_pkg;

  localparam int unsigned NumW = 63;

  typedef enum logic [3:0] {
    PH_PREFIX,
    PH_DEAD,
    PH_START,
    PH_SUF_WS,
    PH_SUF_SIGN,
    PH_SUF_DIG,
    PH_FIRST_WS,
    PH_FIRST_SIGN,
    PH_FIRST_DIG,
    PH_SEC_START,
    PH_SEC_WS,
    PH_SEC_SIGN,
    PH_SEC_DIG,
    PH_SEC_BAD
  } phase_e;

  typedef struct packed {
    logic term;
    logic neg;
    logic comma;
  } flags_t;

  typedef struct packed {
    logic [2:0]      pos;
    phase_e          phase;
    logic [NumW-1:0] first;
    logic [NumW-1:0] second;
    flags_t          flags;
  } parse_state_t;

  localparam parse_state_t StateInit = '{
    pos:    3'd0,
    phase:  PH_PREFIX,
    first:  '0,
    second: '0,
    flags:  '0
  };

  localparam logic [2:0] PrefixLen = 3'd6;

  localparam logic [7:0] ChComma = 8'h2c;
  localparam logic [7:0] ChMinus = 8'h2d;
  localparam logic [7:0] ChPlus  = 8'h2b;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChCr    = 8'h0d;
  localparam logic [7:0] ChNul   = 8'h00;

  localparam logic [1:0] VerdictWhole   = 2'd0;
  localparam logic [1:0] VerdictPartial = 2'd1;
  localparam logic [1:0] VerdictUnsat   = 2'd2;

  // Characters of the literal prefix "bytes=".
  function automatic logic [7:0] prefix_char(logic [2:0] idx);
    logic [7:0] ch;
    unique case (idx)
      3'd0:    ch = 8'h62;
      3'd1:    ch = 8'h79;
      3'd2:    ch = 8'h74;
      3'd3:    ch = 8'h65;
      3'd4:    ch = 8'h73;
      3'd5:    ch = 8'h3d;
      default: ch = ChNul;
    endcase
    return ch;
  endfunction

  // Decimal accumulate that saturates at 2^63-1.
  function automatic logic [NumW-1:0] accumulate(logic [NumW-1:0] acc, logic [7:0] ch);
    logic [3:0]      dig;
    logic [NumW+3:0] prod;
    dig  = 4'(ch - ChZero);
    prod = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {{NumW{1'b0}}, dig};
    return (prod[NumW+3:NumW] != 4'd0) ? {NumW{1'b1}} : prod[NumW-1:0];
  endfunction

endpackage

### src/byte_range_header_parser_unit.sv
// ----------------------------------------------------------------------------
// byte_range_header_parser_unit
// Parses a single-range HTTP Range header value and returns verdict, start
// and length for the file size given with the last character.
// ----------------------------------------------------------------------------
// The block takes one header character per beat, one beat per clock cycle
// unless output backpressure holds a last beat. Each character is parsed
// from the input register into the parser state; the tlast beat also
// latches the file size, and its verdict passes the pending verdict
// register, where the range arithmetic runs, into the output register.
// Parser state returns to its initial value after every last beat, so the
// next header may follow at once. Backpressure on the output stalls only
// the stages that hold a pending verdict; plain characters keep flowing.
module byte_range_header_parser_unit (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  input  logic [71:0]  s_axis_tdata_i,   // header_byte [7:0], file_size [70:8], zero [71]
  input  logic         s_axis_tlast_i,   // is_last
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  output logic [127:0] m_axis_tdata_o    // verdict [1:0], range_start [64:2],
                                         // range_length [127:65]
);
  import brhp_pkg::*;

  // Input register.
  logic            a_valid_q;
  logic [7:0]      a_char_q;
  logic            a_last_q;
  logic [NumW-1:0] a_size_q;

  // Parser state.
  parse_state_t    st_q;
  parse_state_t    st_d;
  parse_state_t    st_next;

  // Pending verdict request.
  logic            b_valid_q;
  parse_state_t    b_state_q;
  logic [NumW-1:0] b_size_q;

  // Output register.
  logic            c_valid_q;
  logic [1:0]      c_verdict_q;
  logic [NumW-1:0] c_start_q;
  logic [NumW-1:0] c_length_q;

  logic            j_verdict;
  logic [1:0]      j_verdict_w;
  logic [NumW-1:0] j_start;
  logic [NumW-1:0] j_length;

  logic            c_ready;
  logic            b_ready;
  logic            a_fire;
  logic            a_ready;
  logic            in_fire;

  assign c_ready = !c_valid_q || m_axis_tready_i;
  assign b_ready = !b_valid_q || c_ready;
  assign a_fire  = a_valid_q && (!a_last_q || b_ready);
  assign a_ready = !a_valid_q || a_fire;
  assign in_fire = s_axis_tvalid_i && a_ready;
  assign j_verdict = b_valid_q && c_ready;

  assign s_axis_tready_o = a_ready;

  brhp_absorb u_absorb (
    .state_i (st_q),
    .char_i  (a_char_q),
    .state_o (st_next)
  );

  brhp_judge u_judge (
    .state_i   (b_state_q),
    .size_i    (b_size_q),
    .verdict_o (j_verdict_w),
    .start_o   (j_start),
    .length_o  (j_length)
  );

  always_comb begin
    st_d = st_q;
    if (a_fire) begin
      st_d = a_last_q ? StateInit : st_next;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
      c_valid_q <= 1'b0;
      st_q      <= StateInit;
    end else begin
      st_q <= st_d;
      if (a_ready) a_valid_q <= s_axis_tvalid_i;
      if (b_ready) b_valid_q <= a_fire && a_last_q;
      if (c_ready) c_valid_q <= b_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      a_char_q <= s_axis_tdata_i[7:0];
      a_size_q <= s_axis_tdata_i[NumW+7:8];
      a_last_q <= s_axis_tlast_i;
    end
    if (a_fire && a_last_q) begin
      b_state_q <= st_next;
      b_size_q  <= a_size_q;
    end
    if (j_verdict) begin
      c_verdict_q <= j_verdict_w;
      c_start_q   <= j_start;
      c_length_q  <= j_length;
    end
  end

  assign m_axis_tvalid_o = c_valid_q;
  assign m_axis_tdata_o  = {c_length_q, c_start_q, c_verdict_q};

endmodule

### src/brhp_absorb.sv
// ----------------------------------------------------------------------------
// brhp_absorb
// Next parse state for one header character: prefix match, grammar position,
// number accumulation and syntax flags.
// ----------------------------------------------------------------------------
module brhp_absorb (
  input  brhp_pkg::parse_state_t state_i,
  input  logic [7:0]             char_i,
  output brhp_pkg::parse_state_t state_o
);
  import brhp_pkg::*;

  logic            is_ws;
  logic            is_digit;
  logic            is_sign;
  logic [NumW-1:0] first_acc;
  logic [NumW-1:0] second_acc;
  parse_state_t    nxt;

  assign is_ws      = (char_i == ChSpace) || ((char_i >= ChTab) && (char_i <= ChCr));
  assign is_digit   = (char_i >= ChZero) && (char_i <= ChNine);
  assign is_sign    = (char_i == ChPlus) || (char_i == ChMinus);
  assign first_acc  = accumulate(state_i.first, char_i);
  assign second_acc = accumulate(state_i.second, char_i);

  always_comb begin
    nxt = state_i;
    if (!state_i.flags.term) begin
      if (char_i == ChNul) begin
        nxt.flags.term = 1'b1;
      end else begin
        if (state_i.phase != PH_PREFIX && state_i.phase != PH_DEAD && char_i == ChComma) begin
          nxt.flags.comma = 1'b1;
        end
        unique case (state_i.phase)
          PH_PREFIX: begin
            if (state_i.pos < PrefixLen && char_i == prefix_char(state_i.pos)) begin
              nxt.pos = state_i.pos + 3'd1;
              if (state_i.pos == PrefixLen - 3'd1) nxt.phase = PH_START;
            end else begin
              nxt.phase = PH_DEAD;
            end
          end
          PH_START, PH_FIRST_WS: begin
            if (state_i.phase == PH_START && char_i == ChMinus) begin
              nxt.phase = PH_SUF_WS;
            end else if (is_ws) begin
              nxt.phase = PH_FIRST_WS;
            end else if (char_i == ChPlus) begin
              nxt.phase = PH_FIRST_SIGN;
            end else if (is_digit) begin
              nxt.first = first_acc;
              nxt.phase = PH_FIRST_DIG;
            end else begin
              nxt.phase = PH_DEAD;
            end
          end
          PH_SUF_WS: begin
            if (is_ws) begin
              nxt.phase = PH_SUF_WS;
            end else if (is_sign) begin
              if (char_i == ChMinus) nxt.flags.neg = 1'b1;
              nxt.phase = PH_SUF_SIGN;
            end else if (is_digit) begin
              nxt.first = first_acc;
              nxt.phase = PH_SUF_DIG;
            end else begin
              nxt.phase = PH_DEAD;
            end
          end
          PH_SUF_SIGN, PH_SUF_DIG: begin
            if (is_digit) begin
              nxt.first = first_acc;
              nxt.phase = PH_SUF_DIG;
            end else begin
              nxt.phase = PH_DEAD;
            end
          end
          PH_FIRST_SIGN: begin
            if (is_digit) begin
              nxt.first = first_acc;
              nxt.phase = PH_FIRST_DIG;
            end else begin
              nxt.phase = PH_DEAD;
            end
          end
          PH_FIRST_DIG: begin
            if (is_digit) begin
              nxt.first = first_acc;
            end else if (char_i == ChMinus) begin
              nxt.phase = PH_SEC_START;
            end else begin
              nxt.phase = PH_DEAD;
            end
          end
          PH_SEC_START, PH_SEC_WS: begin
            if (is_ws) begin
              nxt.phase = PH_SEC_WS;
            end else if (is_sign) begin
              if (char_i == ChMinus) nxt.flags.neg = 1'b1;
              nxt.phase = PH_SEC_SIGN;
            end else if (is_digit) begin
              nxt.second = second_acc;
              nxt.phase  = PH_SEC_DIG;
            end else begin
              nxt.phase = PH_SEC_BAD;
            end
          end
          PH_SEC_SIGN, PH_SEC_DIG: begin
            if (is_digit) begin
              nxt.second = second_acc;
              nxt.phase  = PH_SEC_DIG;
            end else begin
              nxt.phase = PH_SEC_BAD;
            end
          end
          PH_DEAD, PH_SEC_BAD: begin
            nxt.phase = state_i.phase;
          end
          default: begin
            nxt.phase = state_i.phase;
          end
        endcase
      end
    end
  end

  assign state_o = nxt;

endmodule

### src/brhp_judge.sv
// ----------------------------------------------------------------------------
// brhp_judge
// Final verdict for a completed header value against the file size.
// ----------------------------------------------------------------------------
module brhp_judge (
  input  brhp_pkg::parse_state_t     state_i,
  input  logic [brhp_pkg::NumW-1:0] size_i,
  output logic [1:0]                 verdict_o,
  output logic [brhp_pkg::NumW-1:0] start_o,
  output logic [brhp_pkg::NumW-1:0] length_o
);
  import brhp_pkg::*;

  logic            is_second;
  logic            absent;
  logic            end_ok;
  logic [NumW-1:0] suf_len;
  logic [NumW-1:0] end_pos;
  logic [NumW:0]   span;

  assign is_second = (state_i.phase == PH_SEC_START) || (state_i.phase == PH_SEC_WS) ||
                     (state_i.phase == PH_SEC_SIGN)  || (state_i.phase == PH_SEC_DIG) ||
                     (state_i.phase == PH_SEC_BAD);
  assign absent    = (state_i.phase == PH_SEC_START);
  assign end_ok    = absent || ((state_i.phase == PH_SEC_DIG) &&
                                (!state_i.flags.neg || state_i.second == '0));

  // A suffix longer than the file covers the whole file.
  assign suf_len = (state_i.first > size_i) ? size_i : state_i.first;
  assign end_pos = (absent || state_i.second >= size_i) ? size_i - NumW'(1) : state_i.second;
  // The top bit of span is the borrow: set when the end lies below the start.
  assign span    = {1'b0, end_pos} - {1'b0, state_i.first};

  always_comb begin
    verdict_o = VerdictWhole;
    start_o   = '0;
    length_o  = '0;
    if (!state_i.flags.comma) begin
      if (state_i.phase == PH_SUF_DIG) begin
        if (!state_i.flags.neg && suf_len != '0) begin
          verdict_o = VerdictPartial;
          start_o   = size_i - suf_len;
          length_o  = suf_len;
        end
      end else if (is_second) begin
        if (state_i.first >= size_i) begin
          verdict_o = VerdictUnsat;
        end else if (end_ok && !span[NumW]) begin
          verdict_o = VerdictPartial;
          start_o   = state_i.first;
          length_o  = span[NumW-1:0] + NumW'(1);
        end
      end
    end
  end

endmodule
